FILE: hdl/gri_pkg.sv
package gri_pkg;

  localparam int unsigned HistDepth = 256;
  localparam int unsigned HistAw    = $clog2(HistDepth);
  localparam int unsigned CntBits   = HistAw + 1;
  localparam int unsigned RateBits  = 24;

  typedef enum logic [2:0] {
    KIND_RECORD     = 3'd0,
    KIND_CLEAR      = 3'd1,
    KIND_BEGIN      = 3'd2,
    KIND_UPDATE     = 3'd3,
    KIND_INVALIDATE = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    RSN_NONE       = 4'd0,
    RSN_NUMERIC    = 4'd1,
    RSN_NO_HISTORY = 4'd2,
    RSN_RESET      = 4'd3,
    RSN_FORMAT     = 4'd4,
    RSN_INVALID    = 4'd5,
    RSN_SATURATED  = 4'd6,
    RSN_EPOCH      = 4'd7,
    RSN_TIME       = 4'd8,
    RSN_LOSS       = 4'd9
  } reason_e;

  typedef struct packed {
    logic [7:0]          lost;
    logic                full;
    logic                fault;
    logic                sat;
    logic                ok;
    logic [7:0]          epoch;
    logic [RateBits-1:0] rate;
  } info_t;

  typedef struct packed {
    logic [63:0] ts;
    info_t       info;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [HistAw-1:0] waddr;
    entry_t            wdata;
    logic [HistAw-1:0] raddr;
  } mem_req_t;

endpackage

FILE: hdl/gri_hist_mem.sv
module gri_hist_mem (
  input  logic              clk_i,
  input  gri_pkg::mem_req_t req_i,
  output gri_pkg::entry_t   rd_data_o
);
  import gri_pkg::*;

  entry_t mem_q [HistDepth];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rd_q <= mem_q[req_i.raddr];
  end

  assign rd_data_o = rd_q;

endmodule

FILE: hdl/gyro_roll_integrator_core.sv
// Gyro roll integrator: a 256-entry sample ring in one synchronous memory and a serial
// trapezoid integrator. One item is worked on at a time. Record, clear, reset-invalidate,
// unused kinds and an update while the estimate is not live go straight to the result
// state. A live update steps through check, window and multiply, accumulate and result:
// a sample that fails its flag, epoch or time check ends after the check, one outside
// both period windows after window and multiply. Begin flight walks the ring twice through
// the single read port, once to find the seed and once to replay each sample after liftoff
// into the integrator; with no seed it ends after the first walk. A finished result
// waits in the output register, and the next item stalls in its result state until
// that register is taken.
module gyro_roll_integrator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // time stamp, epoch, rate, ok flag, saturation flag, fault flag, fifo full flag,
  // lost count, liftoff time
  input  logic [175:0]  s_axis_tdata,
  // kind
  input  logic [2:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // accepted, estimate_valid, reason code, roll_angle, roll_rate, estimate_time_us,
  // interpolated_count, data_loss_count, fifo_full_count
  output logic [255:0]  m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [1:0]    cfg_index_i,
  input  logic [23:0]   cfg_data_i
);
  import gri_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_SEEK_RD  = 9'b000000010,
    ST_SEEK_CHK = 9'b000000100,
    ST_REP_RD   = 9'b000001000,
    ST_REP_TEST = 9'b000010000,
    ST_CHK1     = 9'b000100000,
    ST_CHK2     = 9'b001000000,
    ST_ACC      = 9'b010000000,
    ST_DONE     = 9'b100000000
  } state_e;

  localparam logic [1:0] CfgBias = 2'd0;
  localparam logic [1:0] CfgPeriod = 2'd1;
  localparam logic [1:0] CfgTol = 2'd2;

  state_e state_q, state_d;

  logic [RateBits-1:0] bias_q;
  logic [15:0]         period_q, tol_q;

  logic [HistAw-1:0]   head_q, head_d;
  logic [CntBits-1:0]  count_q, count_d, k_q, k_d;
  logic                seeded_q, seeded_d, valid_q, valid_d, shown_q, shown_d;
  reason_e             reason_q, reason_d;
  logic [63:0]         acc_q, acc_d, ltime_q, ltime_d;
  logic [24:0]         lrate_q, lrate_d;
  logic [7:0]          fepoch_q, fepoch_d;
  logic [31:0]         interp_q, interp_d, loss_q, loss_d, full_q, full_d;

  logic                found_q, found_d, replay_q, replay_d, ok_q, ok_d;
  logic [63:0]         lift_q, lift_d;
  info_t               seed_q, seed_d;
  entry_t              smp_q, smp_d;
  logic [63:0]         delta_q, delta_d;
  logic [24:0]         rate_q, rate_d;
  logic signed [25:0]  sum_q, sum_d;
  logic signed [43:0]  prod_q, prod_d;

  logic                m_valid_q;
  logic [255:0]        m_data_q;

  mem_req_t            mreq;
  entry_t              rd;
  entry_t              in_entry;
  logic [63:0]         in_lift;
  logic                accept;
  kind_e               kind;

  logic [24:0]         rate_c, seed_rate_c;
  logic [16:0]         e1, e2, lo1, lo2, mul_b;
  logic [17:0]         hi1, hi2, d18;
  logic                dsmall, near1, near2;
  logic [63:0]         inc_c, nsum_c;
  logic                ovf_c;

  gri_hist_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mreq),
    .rd_data_o (rd)
  );

  assign in_entry.ts         = s_axis_tdata[63:0];
  assign in_entry.info.epoch = s_axis_tdata[71:64];
  assign in_entry.info.rate  = s_axis_tdata[95:72];
  assign in_entry.info.ok    = s_axis_tdata[96];
  assign in_entry.info.sat   = s_axis_tdata[97];
  assign in_entry.info.fault = s_axis_tdata[98];
  assign in_entry.info.full  = s_axis_tdata[99];
  assign in_entry.info.lost  = s_axis_tdata[107:100];
  assign in_lift             = s_axis_tdata[171:108];
  assign kind                = kind_e'(s_axis_tuser);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  assign mreq.we    = accept && (kind == KIND_RECORD);
  assign mreq.waddr = head_q;
  assign mreq.wdata = in_entry;
  assign mreq.raddr = head_q - count_q[HistAw-1:0] + k_q[HistAw-1:0];

  // bias-corrected rates
  assign rate_c      = {smp_q.info.rate[RateBits-1], smp_q.info.rate}
                     - {bias_q[RateBits-1], bias_q};
  assign seed_rate_c = {seed_q.rate[RateBits-1], seed_q.rate}
                     - {bias_q[RateBits-1], bias_q};

  // period windows
  assign e1    = {1'b0, period_q};
  assign e2    = {period_q, 1'b0};
  assign lo1   = (e1 > {1'b0, tol_q}) ? e1 - {1'b0, tol_q} : '0;
  assign lo2   = (e2 > {1'b0, tol_q}) ? e2 - {1'b0, tol_q} : '0;
  assign hi1   = {1'b0, e1} + {2'b0, tol_q};
  assign hi2   = {1'b0, e2} + {2'b0, tol_q};
  assign dsmall = (delta_q[63:18] == '0);
  assign d18   = delta_q[17:0];
  assign near1 = dsmall && (d18 >= {1'b0, lo1}) && (d18 <= hi1);
  assign near2 = dsmall && (d18 >= {1'b0, lo2}) && (d18 <= hi2);
  assign mul_b = (near1 && smp_q.info.lost == '0) ? d18[16:0] : e2;

  assign inc_c  = {{20{prod_q[43]}}, prod_q};
  assign nsum_c = acc_q + inc_c;
  assign ovf_c  = (acc_q[63] == inc_c[63]) && (nsum_c[63] != acc_q[63]);

  always_comb begin
    state_d  = state_q;
    head_d   = head_q;
    count_d  = count_q;
    k_d      = k_q;
    seeded_d = seeded_q;
    valid_d  = valid_q;
    shown_d  = shown_q;
    reason_d = reason_q;
    acc_d    = acc_q;
    ltime_d  = ltime_q;
    lrate_d  = lrate_q;
    fepoch_d = fepoch_q;
    interp_d = interp_q;
    loss_d   = loss_q;
    full_d   = full_q;
    found_d  = found_q;
    replay_d = replay_q;
    ok_d     = ok_q;
    lift_d   = lift_q;
    seed_d   = seed_q;
    smp_d    = smp_q;
    delta_d  = delta_q;
    rate_d   = rate_q;
    sum_d    = sum_q;
    prod_d   = prod_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_DONE;
          ok_d    = 1'b0;
          case (kind)
            KIND_RECORD: begin
              head_d = head_q + 1'b1;
              if (count_q != CntBits'(HistDepth)) begin
                count_d = count_q + 1'b1;
              end
              ok_d = 1'b1;
            end
            KIND_CLEAR: begin
              head_d  = '0;
              count_d = '0;
              ok_d    = 1'b1;
            end
            KIND_BEGIN: begin
              seeded_d = 1'b0;
              valid_d  = 1'b0;
              reason_d = RSN_NONE;
              acc_d    = '0;
              lrate_d  = '0;
              ltime_d  = '0;
              fepoch_d = '0;
              interp_d = '0;
              loss_d   = '0;
              full_d   = '0;
              shown_d  = 1'b0;
              found_d  = 1'b0;
              lift_d   = in_lift;
              k_d      = '0;
              state_d  = ST_SEEK_RD;
            end
            KIND_UPDATE: begin
              if (valid_q && seeded_q) begin
                smp_d    = in_entry;
                replay_d = 1'b0;
                state_d  = ST_CHK1;
              end
            end
            KIND_INVALIDATE: begin
              valid_d  = 1'b0;
              reason_d = RSN_RESET;
              ok_d     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_SEEK_RD: begin
        if (k_q == count_q) begin
          if (!found_q) begin
            valid_d  = 1'b0;
            reason_d = RSN_NO_HISTORY;
            ok_d     = 1'b0;
            state_d  = ST_DONE;
          end else begin
            valid_d  = 1'b1;
            reason_d = RSN_NONE;
            ltime_d  = lift_q;
            lrate_d  = seed_rate_c;
            fepoch_d = seed_q.epoch;
            seeded_d = 1'b1;
            replay_d = 1'b1;
            k_d      = '0;
            state_d  = ST_REP_RD;
          end
        end else begin
          state_d = ST_SEEK_CHK;
        end
      end
      ST_SEEK_CHK: begin
        if (rd.ts <= lift_q && rd.info.ok && !rd.info.sat && !rd.info.fault) begin
          seed_d  = rd.info;
          found_d = 1'b1;
        end
        k_d     = k_q + 1'b1;
        state_d = ST_SEEK_RD;
      end
      ST_REP_RD: begin
        if (k_q == count_q) begin
          ok_d    = valid_q;
          state_d = ST_DONE;
        end else begin
          state_d = ST_REP_TEST;
        end
      end
      ST_REP_TEST: begin
        if (rd.ts > lift_q) begin
          smp_d   = rd;
          state_d = ST_CHK1;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = ST_REP_RD;
        end
      end
      ST_CHK1: begin
        if (smp_q.info.full && full_q != '1) begin
          full_d = full_q + 1'b1;
        end
        valid_d = 1'b0;
        ok_d    = 1'b0;
        state_d = ST_DONE;
        if (smp_q.info.fault) begin
          reason_d = RSN_FORMAT;
        end else if (!smp_q.info.ok) begin
          reason_d = RSN_INVALID;
        end else if (smp_q.info.sat) begin
          reason_d = RSN_SATURATED;
        end else if (smp_q.info.epoch != fepoch_q) begin
          reason_d = RSN_EPOCH;
        end else if (smp_q.ts <= ltime_q) begin
          reason_d = RSN_TIME;
        end else begin
          valid_d = valid_q;
          delta_d = smp_q.ts - ltime_q;
          rate_d  = rate_c;
          sum_d   = $signed({lrate_q[24], lrate_q}) + $signed({rate_c[24], rate_c});
          state_d = ST_CHK2;
        end
      end
      ST_CHK2: begin
        prod_d = sum_q * $signed({1'b0, mul_b});
        if (near1 && smp_q.info.lost == '0) begin
          state_d = ST_ACC;
        end else if (near2 && smp_q.info.lost <= 8'd1) begin
          if (interp_q != '1) begin
            interp_d = interp_q + 1'b1;
          end
          if (loss_q != '1) begin
            loss_d = loss_q + 1'b1;
          end
          state_d = ST_ACC;
        end else begin
          if (smp_q.info.lost != '0 && loss_q != '1) begin
            loss_d = loss_q + 1'b1;
          end
          valid_d  = 1'b0;
          reason_d = (smp_q.info.lost > 8'd1) ? RSN_LOSS : RSN_TIME;
          ok_d     = 1'b0;
          state_d  = ST_DONE;
        end
      end
      ST_ACC: begin
        if (ovf_c) begin
          valid_d  = 1'b0;
          reason_d = RSN_NUMERIC;
          ok_d     = 1'b0;
          state_d  = ST_DONE;
        end else begin
          acc_d   = nsum_c;
          lrate_d = rate_q;
          shown_d = 1'b1;
          ltime_d = smp_q.ts;
          if (replay_q) begin
            k_d     = k_q + 1'b1;
            state_d = ST_REP_RD;
          end else begin
            ok_d    = 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!m_valid_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      bias_q    <= '0;
      period_q  <= 16'd1000;
      tol_q     <= 16'd250;
      head_q    <= '0;
      count_q   <= '0;
      k_q       <= '0;
      seeded_q  <= 1'b0;
      valid_q   <= 1'b0;
      shown_q   <= 1'b0;
      reason_q  <= RSN_NONE;
      acc_q     <= '0;
      ltime_q   <= '0;
      lrate_q   <= '0;
      fepoch_q  <= '0;
      interp_q  <= '0;
      loss_q    <= '0;
      full_q    <= '0;
      found_q   <= 1'b0;
      replay_q  <= 1'b0;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      head_q   <= head_d;
      count_q  <= count_d;
      k_q      <= k_d;
      seeded_q <= seeded_d;
      valid_q  <= valid_d;
      shown_q  <= shown_d;
      reason_q <= reason_d;
      acc_q    <= acc_d;
      ltime_q  <= ltime_d;
      lrate_q  <= lrate_d;
      fepoch_q <= fepoch_d;
      interp_q <= interp_d;
      loss_q   <= loss_d;
      full_q   <= full_d;
      found_q  <= found_d;
      replay_q <= replay_d;
      ok_q     <= ok_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgBias:   bias_q   <= cfg_data_i[RateBits-1:0];
          CfgPeriod: period_q <= cfg_data_i[15:0];
          CfgTol:    tol_q    <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lift_q  <= lift_d;
    seed_q  <= seed_d;
    smp_q   <= smp_d;
    delta_q <= delta_d;
    rate_q  <= rate_d;
    sum_q   <= sum_d;
    prod_q  <= prod_d;
    if (state_q == ST_DONE && (!m_valid_q || m_axis_tready)) begin
      m_data_q <= {1'b0, full_q, loss_q, interp_q, ltime_q,
                   (shown_q ? lrate_q : 25'd0), acc_q, reason_q, valid_q, ok_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule
